// ===== hw/rtl/uvs_pkg.sv =====
// Shared types, constants and small tables for the UV sphere vertex generator.
`default_nettype none

package uvs_pkg;

   // Configuration register indexes
   localparam logic [1:0] REG_RADIUS      = 2'd0;
   localparam logic [1:0] REG_SLICE_COUNT = 2'd1;
   localparam logic [1:0] REG_STACK_COUNT = 2'd2;

   // Divide operations, selected by op[2:1] in the back end
   localparam logic [1:0] OP_RHO = 2'd0;
   localparam logic [1:0] OP_TH  = 2'd1;
   localparam logic [1:0] OP_S   = 2'd2;
   localparam logic [1:0] OP_T   = 2'd3;

   localparam logic [2:0] LAST_OP   = 3'd7;
   localparam logic [2:0] LAST_BEAT = 3'd5;
   localparam logic [2:0] LAST_TERM = 3'd4;

   // Q30 fixed point constants for the sine series
   localparam logic [31:0] ONE_Q30     = 32'd1073741824;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [15:0] HALF_PI_LO  = HALF_PI_Q30[15:0];
   localparam logic [15:0] HALF_PI_HI  = HALF_PI_Q30[31:16];

   typedef struct packed {
      logic [9:0] stack_index;
      logic [9:0] slice_index;
      logic       bad;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_DIV,
      B_SIN,
      B_EMIT
   } back_state_type;

   typedef enum logic [2:0] {
      SIN_IDLE,
      SIN_ALO,
      SIN_AHI,
      SIN_A2,
      SIN_X,
      SIN_Q,
      SIN_U,
      SIN_S
   } sin_state_type;

   // Horner divisors of the series, innermost first
   function automatic logic [6:0] taylor_div(input logic [2:0] k);
      logic [6:0] d;
      case (k)
         3'd0: d = 7'd110;
         3'd1: d = 7'd72;
         3'd2: d = 7'd42;
         3'd3: d = 7'd20;
         3'd4: d = 7'd6;
         default: d = 7'd6;
      endcase
      return d;
   endfunction

   // floor(2^32 / divisor)
   function automatic logic [31:0] taylor_recip(input logic [2:0] k);
      logic [31:0] r;
      case (k)
         3'd0: r = 32'd39045157;
         3'd1: r = 32'd59652323;
         3'd2: r = 32'd102261126;
         3'd3: r = 32'd214748364;
         3'd4: r = 32'd715827882;
         default: r = 32'd715827882;
      endcase
      return r;
   endfunction

   // Corner order: (i,j) (i+1,j) (i,j+1) (i+1,j) (i+1,j+1) (i,j+1)
   function automatic logic corner_dr(input logic [2:0] beat);
      logic v;
      case (beat)
         3'd1, 3'd3, 3'd4: v = 1'b1;
         default: v = 1'b0;
      endcase
      return v;
   endfunction

   function automatic logic corner_dc(input logic [2:0] beat);
      logic v;
      case (beat)
         3'd2, 3'd4, 3'd5: v = 1'b1;
         default: v = 1'b0;
      endcase
      return v;
   endfunction

   // Signed product shifted right 15, rounded half away from zero
   function automatic logic signed [18:0] round15(input logic signed [33:0] p);
      logic        neg;
      logic [33:0] mag;
      logic [18:0] r;
      neg = p[33];
      mag = neg ? 34'(-p) : 34'(p);
      r   = 19'((mag + 34'd16384) >> 15);
      return neg ? 19'(-r) : r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/uvs_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module uvs_div import uvs_pkg::*; #(
   parameter int DW = 28
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] num,
   input  wire logic [11:0]   den,
   output logic               done,
   output logic [DW-1:0]      quot
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [11:0]   rem_ff, rem_in;
   logic [11:0]   den_ff, den_in;
   logic [DW-1:0] num_ff, num_in;

   logic [12:0] trial;
   logic [12:0] diff;
   logic        ge;

   always_comb begin
      trial   = {rem_ff, num_ff[DW-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         num_in  = num;
      end else if (busy_ff) begin
         rem_in = ge ? diff[11:0] : trial[11:0];
         num_in = {num_ff[DW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/uvs_sin.sv =====
// Iterative sine of a phase: quadrant fold, then an 11th-degree series in Q30.
`default_nettype none

module uvs_sin import uvs_pkg::*; #(
   parameter int TRIG_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [TRIG_BITS-1:0] phase,
   output logic                      done,
   output logic signed [15:0]        value
);

   localparam int QW = TRIG_BITS - 1;
   localparam logic [QW-1:0] QTR = QW'(1) << (TRIG_BITS - 2);

   sin_state_type state_ff, state_in;

   logic [QW-1:0]    rr_ff, rr_in;
   logic             neg_ff, neg_in;
   logic [QW+15:0]   lo_ff, lo_in;
   logic [31:0]      a_ff, a_in;
   logic [31:0]      a2_ff, a2_in;
   logic [31:0]      u_ff, u_in;
   logic [31:0]      x_ff, x_in;
   logic [31:0]      q_ff, q_in;
   logic [2:0]       k_ff, k_in;
   logic             done_ff, done_in;
   logic signed [15:0] value_ff, value_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [QW-1:0] r0;
   logic [31:0] qd;
   logic [31:0] rem;
   logic [31:0] qc;
   logic [63:0] a_sum;
   logic [17:0] qs;
   logic [15:0] qsat;

   assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

   always_comb begin
      state_in = state_ff;
      rr_in    = rr_ff;
      neg_in   = neg_ff;
      lo_in    = lo_ff;
      a_in     = a_ff;
      a2_in    = a2_ff;
      u_in     = u_ff;
      x_in     = x_ff;
      q_in     = q_ff;
      k_in     = k_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      mul_a    = '0;
      mul_b    = '0;
      r0       = {1'b0, phase[TRIG_BITS-3:0]};
      qd       = q_ff * {25'b0, taylor_div(k_ff)};
      rem      = x_ff - qd;
      qc       = q_ff + 32'(rem >= {25'b0, taylor_div(k_ff)});
      a_sum    = '0;
      qs       = '0;
      qsat     = '0;
      case (state_ff)
         SIN_IDLE: begin
            if (start) begin
               rr_in    = phase[TRIG_BITS-2] ? (QTR - r0) : r0;
               neg_in   = phase[TRIG_BITS-1];
               state_in = SIN_ALO;
            end
         end
         SIN_ALO: begin
            mul_a    = 32'(rr_ff);
            mul_b    = {16'b0, HALF_PI_LO};
            lo_in    = mul_p[QW+15:0];
            state_in = SIN_AHI;
         end
         SIN_AHI: begin
            mul_a    = 32'(rr_ff);
            mul_b    = {16'b0, HALF_PI_HI};
            a_sum    = {mul_p[47:0], 16'b0} + 64'(lo_ff);
            a_in     = 32'(a_sum >> (TRIG_BITS - 2));
            state_in = SIN_A2;
         end
         SIN_A2: begin
            mul_a    = a_ff;
            mul_b    = a_ff;
            a2_in    = mul_p[61:30];
            u_in     = ONE_Q30;
            k_in     = '0;
            state_in = SIN_X;
         end
         SIN_X: begin
            mul_a    = a2_ff;
            mul_b    = u_ff;
            x_in     = mul_p[61:30];
            state_in = SIN_Q;
         end
         SIN_Q: begin
            mul_a    = x_ff;
            mul_b    = taylor_recip(k_ff);
            q_in     = mul_p[63:32];
            state_in = SIN_U;
         end
         SIN_U: begin
            // reciprocal estimate is low by at most one
            u_in = ONE_Q30 - qc;
            if (k_ff == LAST_TERM) begin
               state_in = SIN_S;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = SIN_X;
            end
         end
         SIN_S: begin
            mul_a    = a_ff;
            mul_b    = u_ff;
            qs       = 18'(({1'b0, mul_p[61:30]} + 33'd16384) >> 15);
            qsat     = (qs > 18'd32767) ? 16'd32767 : qs[15:0];
            value_in = neg_ff ? 16'(-$signed(qsat)) : $signed(qsat);
            done_in  = 1'b1;
            state_in = SIN_IDLE;
         end
         default: state_in = SIN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SIN_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rr_ff    <= rr_in;
      neg_ff   <= neg_in;
      lo_ff    <= lo_in;
      a_ff     <= a_in;
      a2_ff    <= a2_in;
      u_ff     <= u_in;
      x_ff     <= x_in;
      q_ff     <= q_in;
      k_ff     <= k_in;
      value_ff <= value_in;
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/uvs_front.sv =====
// Front end: takes request beats, flags bad indexes, queues them two deep.
`default_nettype none

module uvs_front import uvs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [9:0]  req_stack_index,
   input  wire logic [9:0]  req_slice_index,
   input  wire logic [10:0] stacks,
   input  wire logic [10:0] slices,
   input  wire logic        pop,
   output queue_head_type   head
);

   item_type   ent_ff [2];
   item_type   ent_in;
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       take;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign take      = pop && (cnt_ff != 2'd0);

   always_comb begin
      ent_in.stack_index = req_stack_index;
      ent_in.slice_index = req_slice_index;
      ent_in.bad = ({1'b0, req_stack_index} >= stacks) || ({1'b0, req_slice_index} >= slices);
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = take ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         ent_ff[wr_ff] <= ent_in;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = ent_ff[rd_ff];

endmodule

`default_nettype wire

// ===== hw/rtl/uvs_back.sv =====
// Back end: per quad divides and sines, then a two-stage vertex output pipe.
`default_nettype none

module uvs_back import uvs_pkg::*; #(
   parameter int TRIG_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire queue_head_type head,
   output logic             pop,
   input  wire logic [15:0] radius,
   input  wire logic [10:0] stacks,
   input  wire logic [10:0] slices,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [15:0]      rsp_tex_s,
   output logic [15:0]      rsp_tex_t,
   output logic             rsp_last_vertex,
   output logic             rsp_bad_index
);

   localparam int SH = (TRIG_BITS > 15) ? TRIG_BITS : 15;
   localparam int DW = SH + 12;
   localparam logic [TRIG_BITS-1:0] QUARTER = TRIG_BITS'(1) << (TRIG_BITS - 2);

   back_state_type state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic       run_ff, run_in;
   logic [2:0] beat_ff, beat_in;
   item_type   item_ff, item_in;

   logic [TRIG_BITS-1:0] rho_ff [2];
   logic [TRIG_BITS-1:0] th_ff [2];
   logic [15:0]          s_ff [2];
   logic [15:0]          t_ff [2];
   logic signed [15:0]   srho_ff [2];
   logic signed [15:0]   crho_ff [2];
   logic signed [15:0]   nsth_ff [2];
   logic signed [15:0]   cth_ff [2];

   // divider / sine unit hookup
   logic          div_start, div_done;
   logic [DW-1:0] div_num, div_quot;
   logic [11:0]   div_den;
   logic          sin_start, sin_done;
   logic [TRIG_BITS-1:0] sin_phase;
   logic signed [15:0]   sin_value;
   logic [10:0]   ring, col;

   // output pipe
   logic               adv;
   logic               e1_v_ff;
   logic signed [31:0] pnx_ff, pny_ff;
   logic signed [15:0] crho_e1_ff;
   logic [15:0]        s_e1_ff, t_e1_ff;
   logic               last_e1_ff, bad_e1_ff;
   logic               rs, cs;

   logic               out_v_ff;
   logic signed [16:0] px_ff, py_ff, pz_ff;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic [15:0]        ts_ff, tt_ff;
   logic               last_ff, bad_ff;

   logic signed [18:0] nx_r, ny_r, px_r, py_r, pz_r;
   logic signed [33:0] rad34;

   uvs_div #(.DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   uvs_sin #(.TRIG_BITS(TRIG_BITS)) u_sin (
      .clock (clock),
      .reset (reset),
      .start (sin_start),
      .phase (sin_phase),
      .done  (sin_done),
      .value (sin_value)
   );

   assign adv = !out_v_ff || !rsp_stall;

   // divide operands
   always_comb begin
      ring = {1'b0, item_ff.stack_index} + 11'(op_ff[0]);
      col  = {1'b0, item_ff.slice_index} + 11'(op_ff[0]);
      case (op_ff[2:1])
         OP_RHO: begin
            div_num = (DW'(ring) << TRIG_BITS) + DW'(stacks);
            div_den = {stacks, 1'b0};
         end
         OP_TH: begin
            div_num = (DW'(col) << TRIG_BITS) + DW'(slices[10:1]);
            div_den = {1'b0, slices};
         end
         OP_S: begin
            div_num = (DW'(col) << 15) + DW'(slices[10:1]);
            div_den = {1'b0, slices};
         end
         OP_T: begin
            div_num = (DW'(stacks - ring) << 15) + DW'(stacks[10:1]);
            div_den = {1'b0, stacks};
         end
         default: begin
            div_num = '0;
            div_den = {1'b0, stacks};
         end
      endcase
      sin_phase = (op_ff[2] ? th_ff[op_ff[1]] : rho_ff[op_ff[1]])
                  + (op_ff[0] ? QUARTER : '0);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      run_in    = run_ff;
      beat_in   = beat_ff;
      item_in   = item_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      sin_start = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               item_in  = head.item;
               op_in    = '0;
               run_in   = 1'b0;
               beat_in  = '0;
               state_in = head.item.bad ? B_EMIT : B_DIV;
            end
         end
         B_DIV: begin
            if (!run_ff) begin
               div_start = 1'b1;
               run_in    = 1'b1;
            end else if (div_done) begin
               run_in = 1'b0;
               op_in  = op_ff + 1'b1;
               if (op_ff == LAST_OP) begin
                  state_in = B_SIN;
               end
            end
         end
         B_SIN: begin
            if (!run_ff) begin
               sin_start = 1'b1;
               run_in    = 1'b1;
            end else if (sin_done) begin
               run_in = 1'b0;
               op_in  = op_ff + 1'b1;
               if (op_ff == LAST_OP) begin
                  state_in = B_EMIT;
               end
            end
         end
         B_EMIT: begin
            if (adv) begin
               beat_in = beat_ff + 1'b1;
               if (beat_ff == LAST_BEAT) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         run_ff   <= 1'b0;
         beat_ff  <= '0;
         op_ff    <= '0;
      end else begin
         state_ff <= state_in;
         run_ff   <= run_in;
         beat_ff  <= beat_in;
         op_ff    <= op_in;
      end
      item_ff <= item_in;
      if (state_ff == B_DIV && run_ff && div_done) begin
         case (op_ff[2:1])
            OP_RHO:  rho_ff[op_ff[0]] <= div_quot[TRIG_BITS-1:0];
            OP_TH:   th_ff[op_ff[0]]  <= div_quot[TRIG_BITS-1:0];
            OP_S:    s_ff[op_ff[0]]   <= div_quot[15:0];
            OP_T:    t_ff[op_ff[0]]   <= div_quot[15:0];
            default: rho_ff[op_ff[0]] <= div_quot[TRIG_BITS-1:0];
         endcase
      end
      if (state_ff == B_SIN && run_ff && sin_done) begin
         case ({op_ff[2], op_ff[0]})
            2'b00:   srho_ff[op_ff[1]] <= sin_value;
            2'b01:   crho_ff[op_ff[1]] <= sin_value;
            2'b10:   nsth_ff[op_ff[1]] <= 16'(-sin_value);
            2'b11:   cth_ff[op_ff[1]]  <= sin_value;
            default: srho_ff[op_ff[1]] <= sin_value;
         endcase
      end
   end

   // stage 1: pick the corner, form the normal products
   assign rs = corner_dr(beat_ff);
   assign cs = corner_dc(beat_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_v_ff <= 1'b0;
      end else if (adv) begin
         e1_v_ff <= (state_ff == B_EMIT);
      end
      if (adv) begin
         last_e1_ff <= (beat_ff == LAST_BEAT);
         bad_e1_ff  <= item_ff.bad;
         if (item_ff.bad) begin
            pnx_ff     <= '0;
            pny_ff     <= '0;
            crho_e1_ff <= '0;
            s_e1_ff    <= '0;
            t_e1_ff    <= '0;
         end else begin
            pnx_ff     <= {{16{nsth_ff[cs][15]}}, nsth_ff[cs]}
                          * {{16{srho_ff[rs][15]}}, srho_ff[rs]};
            pny_ff     <= {{16{cth_ff[cs][15]}}, cth_ff[cs]}
                          * {{16{srho_ff[rs][15]}}, srho_ff[rs]};
            crho_e1_ff <= crho_ff[rs];
            s_e1_ff    <= s_ff[cs];
            t_e1_ff    <= t_ff[rs];
         end
      end
   end

   // stage 2: round normals, scale by radius
   always_comb begin
      rad34 = {18'b0, radius};
      nx_r  = round15({{2{pnx_ff[31]}}, pnx_ff});
      ny_r  = round15({{2{pny_ff[31]}}, pny_ff});
      px_r  = round15({{18{nx_r[15]}}, nx_r[15:0]} * rad34);
      py_r  = round15({{18{ny_r[15]}}, ny_r[15:0]} * rad34);
      pz_r  = round15({{18{crho_e1_ff[15]}}, crho_e1_ff} * rad34);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= e1_v_ff;
      end
      if (adv) begin
         px_ff   <= px_r[16:0];
         py_ff   <= py_r[16:0];
         pz_ff   <= pz_r[16:0];
         nx_ff   <= nx_r[15:0];
         ny_ff   <= ny_r[15:0];
         nz_ff   <= crho_e1_ff;
         ts_ff   <= s_e1_ff;
         tt_ff   <= t_e1_ff;
         last_ff <= last_e1_ff;
         bad_ff  <= bad_e1_ff;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_pos_x       = px_ff;
   assign rsp_pos_y       = py_ff;
   assign rsp_pos_z       = pz_ff;
   assign rsp_norm_x      = nx_ff;
   assign rsp_norm_y      = ny_ff;
   assign rsp_norm_z      = nz_ff;
   assign rsp_tex_s       = ts_ff;
   assign rsp_tex_t       = tt_ff;
   assign rsp_last_vertex = last_ff;
   assign rsp_bad_index   = bad_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/uv_sphere_vertex_generator.sv =====
// UV sphere vertex generator: top level with configuration registers.
//
// One request beat names a quad (stack row, slice column) of a UV sphere.
// The block answers with six response beats, the vertices of the quad's two
// triangles: position (Q8.8), normal (Q1.15) and texture s/t (Q1.15).
// last_vertex marks the sixth beat; bad_index is set on all six when an
// index is not below its count, and then every coordinate is zero.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. The csr port writes radius, slice_count and stack_count; write
// only while the block is idle.
// A two-entry queue takes requests while the back end works. An in-range
// quad runs eight serial divides and eight sines on one shared multiplier,
// then six output beats; only then does the back end pop the next quad. An
// out-of-range quad skips the divides and sines. After the last sine result
// the sequencer enters its emit state and each beat passes the stage-1 and
// output registers. Reset empties the queue and pipe and loads radius 1.0
// and 16 slices and stacks. A stalled receiver holds the output register
// and the back end; the queue then fills and req_stall rises.
`default_nettype none

module uv_sphere_vertex_generator import uvs_pkg::*; #(
   parameter int MAX_DIVISIONS = 1024,
   parameter int TRIG_BITS     = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [9:0]  req_stack_index,
   input  wire logic [9:0]  req_slice_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [15:0]      rsp_tex_s,
   output logic [15:0]      rsp_tex_t,
   output logic             rsp_last_vertex,
   output logic             rsp_bad_index,
   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   logic [15:0] radius_ff;
   logic [10:0] slice_count_ff;
   logic [10:0] stack_count_ff;
   logic [10:0] stacks, slices;
   queue_head_type head;
   logic           pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff      <= 16'd256;
         slice_count_ff <= 11'd16;
         stack_count_ff <= 11'd16;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_RADIUS:      radius_ff      <= csr_data;
            REG_SLICE_COUNT: slice_count_ff <= csr_data[10:0];
            REG_STACK_COUNT: stack_count_ff <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   // counts above the limit act as the limit
   assign stacks = ({2'b0, stack_count_ff} > 13'(MAX_DIVISIONS)) ? 11'(MAX_DIVISIONS)
                                                                  : stack_count_ff;
   assign slices = ({2'b0, slice_count_ff} > 13'(MAX_DIVISIONS)) ? 11'(MAX_DIVISIONS)
                                                                  : slice_count_ff;

   uvs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stack_index (req_stack_index),
      .req_slice_index (req_slice_index),
      .stacks          (stacks),
      .slices          (slices),
      .pop             (pop),
      .head            (head)
   );

   uvs_back #(.TRIG_BITS(TRIG_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .radius          (radius_ff),
      .stacks          (stacks),
      .slices          (slices),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_norm_x      (rsp_norm_x),
      .rsp_norm_y      (rsp_norm_y),
      .rsp_norm_z      (rsp_norm_z),
      .rsp_tex_s       (rsp_tex_s),
      .rsp_tex_t       (rsp_tex_t),
      .rsp_last_vertex (rsp_last_vertex),
      .rsp_bad_index   (rsp_bad_index)
   );

   // out-of-range quads carry zero pos_x, norm_z and texture coordinates
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_index |-> rsp_pos_x == 17'sd0 && rsp_norm_z == 16'sd0
         && rsp_tex_s == 16'd0 && rsp_tex_t == 16'd0)
      else $error("bad quad with nonzero coordinates");

   // texture coordinates never pass 1.0
   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tex_s <= 16'd32768 && rsp_tex_t <= 16'd32768)
      else $error("texture coordinate above one");

   // saturated trig keeps normals off the most negative code
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_norm_x != 16'sh8000 && rsp_norm_y != 16'sh8000
         && rsp_norm_z != 16'sh8000)
      else $error("normal out of range");

   // the back end pops only when free, and only while the queue holds an entry
   a_pop_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== sim/uv_sphere_vertex_generator_tb.sv =====
// Testbench for the UV sphere vertex generator: directed and random quads, predicted vertices.
`timescale 1ns / 100ps

module uv_sphere_vertex_generator_tb;
   import uvs_pkg::*;

   // Index with no register behind it; writes must be dropped
   localparam logic [1:0] REG_NONE = 2'd3;
   localparam int MAX_DIV = 1024;
   localparam int LONG_HOLD = 2000;
   localparam int RANDOM_PHASES = 6;
   localparam int QUADS_PER_PHASE = 25;

   typedef struct {
      logic signed [16:0] pos_x, pos_y, pos_z;
      logic signed [15:0] norm_x, norm_y, norm_z;
      logic [15:0]        tex_s, tex_t;
      logic               last_vertex, bad_index;
   } vertex_type;

   // One directed quad. typed_bad: expectation is typed in (zeroed, flagged)
   typedef struct {
      int         phase;
      logic [9:0] stack_index, slice_index;
      logic       typed_bad;
   } quad_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [9:0] req_stack_index = '0;
   logic [9:0] req_slice_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [16:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [15:0] rsp_tex_s, rsp_tex_t;
   logic rsp_last_vertex, rsp_bad_index;
   logic csr_write_en = 1'b0;
   logic [1:0] csr_index = REG_RADIUS;
   logic [15:0] csr_data = '0;

   // Model copy of the registers
   int unsigned radius_q88 = 256;
   int unsigned slice_reg = 16;
   int unsigned stack_reg = 16;

   vertex_type pending_vertices[$];
   int errors = 0;
   int unsigned rsp_beats = 0;
   bit hold_rsp = 1'b0;   // request a long receiver hold-off
   bit burst_req = 1'b0;  // sender offers back to back while set

   uv_sphere_vertex_generator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_stack_index(req_stack_index), .req_slice_index(req_slice_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_norm_x(rsp_norm_x), .rsp_norm_y(rsp_norm_y), .rsp_norm_z(rsp_norm_z),
      .rsp_tex_s(rsp_tex_s), .rsp_tex_t(rsp_tex_t),
      .rsp_last_vertex(rsp_last_vertex), .rsp_bad_index(rsp_bad_index),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Vertex predictor
   // ---------------------------------------------------------------

   // Sine over one quadrant: degree-11 Taylor in Q30 (Horner, truncating),
   // then rounded to Q1.15 half up and clipped at 32767
   function automatic longint quadrant_sine(int unsigned r);
      longint unsigned divs[5];
      longint unsigned a, a2, u, s, q;
      divs = '{110, 72, 42, 20, 6};
      a  = (longint'(r) * 64'd1686629713) >> 14;
      a2 = (a * a) >> 30;
      u  = 64'd1 << 30;
      for (int k = 0; k < 5; k++)
         u = (64'd1 << 30) - (((a2 * u) >> 30) / divs[k]);
      s = (a * u) >> 30;
      q = (s + 64'd16384) >> 15;
      if (q > 32767) q = 32767;
      return longint'(q);
   endfunction

   // Sine of a 16-bit phase (one full turn = 2^16)
   function automatic longint phase_sine(int unsigned p);
      int unsigned quad, r;
      longint v;
      p    = p & 32'hFFFF;
      quad = p >> 14;
      r    = p & 32'h3FFF;
      v    = quad[0] ? quadrant_sine(16384 - r) : quadrant_sine(r);
      return (quad >= 2) ? -v : v;
   endfunction

   function automatic longint mul_q15(longint a, longint b);
      longint p;
      longint unsigned m;
      p = a * b;
      m = (p < 0) ? longint'(-p) : p;
      m = (m + 64'd16384) >> 15;
      return (p < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic vertex_type sphere_vertex(int unsigned ring, int unsigned col,
                                                int unsigned stacks, int unsigned slices);
      vertex_type v;
      int unsigned rho, th;
      longint srho, nx, ny, nz;
      longint unsigned s, t;
      rho  = ((longint'(ring) << 16) + stacks) / (2 * stacks);
      th   = ((longint'(col) << 16) + slices / 2) / slices;
      srho = phase_sine(rho);
      nx   = mul_q15(-phase_sine(th), srho);
      ny   = mul_q15(phase_sine(th + 16384), srho);
      nz   = phase_sine(rho + 16384);
      s    = ((longint'(col) << 15) + slices / 2) / slices;
      t    = ((longint'(stacks - ring) << 15) + stacks / 2) / stacks;
      v.pos_x  = 17'(mul_q15(nx, radius_q88));
      v.pos_y  = 17'(mul_q15(ny, radius_q88));
      v.pos_z  = 17'(mul_q15(nz, radius_q88));
      v.norm_x = 16'(nx);
      v.norm_y = 16'(ny);
      v.norm_z = 16'(nz);
      v.tex_s  = 16'(s);
      v.tex_t  = 16'(t);
      v.last_vertex = 1'b0;
      v.bad_index   = 1'b0;
      return v;
   endfunction

   // Queue the six vertices of a quad, in triangle order
   function automatic void predict_quad(int unsigned i, int unsigned j);
      bit dr[6];
      bit dc[6];
      int unsigned stacks, slices;
      vertex_type v;
      dr = '{0, 1, 0, 1, 1, 0};
      dc = '{0, 0, 1, 0, 1, 1};
      stacks = (stack_reg > MAX_DIV) ? MAX_DIV : stack_reg;
      slices = (slice_reg > MAX_DIV) ? MAX_DIV : slice_reg;
      for (int k = 0; k < 6; k++) begin
         if (i >= stacks || j >= slices) begin
            v = '{default: '0};
            v.bad_index = 1'b1;
         end else begin
            v = sphere_vertex(i + dr[k], j + dc[k], stacks, slices);
         end
         v.last_vertex = (k == 5);
         pending_vertices.push_back(v);
      end
   endfunction

   // Hand-typed answer for an out-of-range quad: all zero, flagged
   function automatic void expect_rejected_quad();
      vertex_type v;
      for (int k = 0; k < 6; k++) begin
         v = '{default: '0};
         v.bad_index   = 1'b1;
         v.last_vertex = (k == 5);
         pending_vertices.push_back(v);
      end
   endfunction

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------

   // Offer one quad; returns after the beat is taken. Valid stays high
   // so the next quad can follow with no gap.
   task automatic send_quad(logic [9:0] i, logic [9:0] j, bit typed_bad);
      int gap;
      gap = burst_req ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stack_index <= i;
      req_slice_index <= j;
      do @(posedge clock); while (req_stall);
      if (typed_bad) expect_rejected_quad();
      else predict_quad(i, j);
   endtask

   // Wait until the block has drained, then write one register
   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      req_valid <= 1'b0;
      wait (pending_vertices.size() == 0);
      repeat (20) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_RADIUS:      radius_q88 = data;
         REG_SLICE_COUNT: slice_reg  = data[10:0];
         REG_STACK_COUNT: stack_reg  = data[10:0];
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------
   // Response side: random stall per beat, one long hold-off on request
   // ---------------------------------------------------------------
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            n = LONG_HOLD;
            hold_rsp = 1'b0;
         end else if ((rsp_beats % 64) < 16) begin
            n = 0;   // stretch with a free-running receiver
         end else begin
            n = $urandom_range(0, 8);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Compare each response beat with the oldest expected vertex
   always @(posedge clock) begin
      vertex_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_beats <= rsp_beats + 1;
         if (pending_vertices.size() == 0) begin
            $error("unexpected vertex beat");
            errors++;
         end else begin
            e = pending_vertices.pop_front();
            if (rsp_pos_x !== e.pos_x) begin
               $error("pos_x exp %0d got %0d", e.pos_x, rsp_pos_x); errors++;
            end
            if (rsp_pos_y !== e.pos_y) begin
               $error("pos_y exp %0d got %0d", e.pos_y, rsp_pos_y); errors++;
            end
            if (rsp_pos_z !== e.pos_z) begin
               $error("pos_z exp %0d got %0d", e.pos_z, rsp_pos_z); errors++;
            end
            if (rsp_norm_x !== e.norm_x) begin
               $error("norm_x exp %0d got %0d", e.norm_x, rsp_norm_x); errors++;
            end
            if (rsp_norm_y !== e.norm_y) begin
               $error("norm_y exp %0d got %0d", e.norm_y, rsp_norm_y); errors++;
            end
            if (rsp_norm_z !== e.norm_z) begin
               $error("norm_z exp %0d got %0d", e.norm_z, rsp_norm_z); errors++;
            end
            if (rsp_tex_s !== e.tex_s) begin
               $error("tex_s exp %0d got %0d", e.tex_s, rsp_tex_s); errors++;
            end
            if (rsp_tex_t !== e.tex_t) begin
               $error("tex_t exp %0d got %0d", e.tex_t, rsp_tex_t); errors++;
            end
            if (rsp_last_vertex !== e.last_vertex) begin
               $error("last_vertex exp %0b got %0b", e.last_vertex, rsp_last_vertex);
               errors++;
            end
            if (rsp_bad_index !== e.bad_index) begin
               $error("bad_index exp %0b got %0b", e.bad_index, rsp_bad_index);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   quad_row_type directed[] = '{
      // reset setting: radius 1.0, 16 x 16
      '{0, 10'd0,    10'd0,    1'b0},   // north pole quad
      '{0, 10'd15,   10'd15,   1'b0},   // south pole, azimuth wrap
      '{0, 10'd7,    10'd3,    1'b0},
      '{0, 10'd8,    10'd12,   1'b0},
      '{0, 10'd16,   10'd0,    1'b1},   // stack just out of range
      '{0, 10'd0,    10'd16,   1'b1},   // slice just out of range
      '{0, 10'd1023, 10'd1023, 1'b1},
      // largest radius, single slice and stack
      '{1, 10'd0,    10'd0,    1'b0},
      '{1, 10'd0,    10'd1,    1'b1},
      '{1, 10'd1,    10'd0,    1'b1},
      // zero radius, counts over the limit clamp to 1024
      '{2, 10'd1023, 10'd1023, 1'b0},
      '{2, 10'd512,  10'd0,    1'b0},
      '{2, 10'd0,    10'd1023, 1'b0},
      '{2, 10'd341,  10'd682,  1'b0},
      // zero slice count: everything out of range
      '{3, 10'd0,    10'd0,    1'b1},
      '{3, 10'd5,    10'd1,    1'b1},
      // odd small counts, stray register write ignored
      '{4, 10'd0,    10'd4,    1'b0},
      '{4, 10'd2,    10'd0,    1'b0},
      '{4, 10'd1,    10'd2,    1'b0}
   };

   initial begin
      int cur_phase;
      int unsigned slices_eff, stacks_eff;
      logic [9:0] i, j;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur_phase = 0;
      foreach (directed[r]) begin
         if (directed[r].phase != cur_phase) begin
            cur_phase = directed[r].phase;
            case (cur_phase)
               1: begin
                  write_reg(REG_RADIUS, 16'hFFFF);
                  write_reg(REG_SLICE_COUNT, 16'd1);
                  write_reg(REG_STACK_COUNT, 16'd1);
               end
               2: begin
                  write_reg(REG_RADIUS, 16'd0);
                  write_reg(REG_SLICE_COUNT, 16'd2047);
                  write_reg(REG_STACK_COUNT, 16'd1024);
               end
               3: write_reg(REG_SLICE_COUNT, 16'd0);
               4: begin
                  write_reg(REG_RADIUS, 16'd640);
                  write_reg(REG_SLICE_COUNT, 16'd5);
                  write_reg(REG_STACK_COUNT, 16'd3);
                  write_reg(REG_NONE, 16'hFFFF);
               end
               default: ;
            endcase
         end
         send_quad(directed[r].stack_index, directed[r].slice_index,
                   directed[r].typed_bad);
      end

      // Random phases: mostly small meshes with in-range quads
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_reg(REG_RADIUS, 16'($urandom));
         write_reg(REG_SLICE_COUNT,
                   ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 2047))
                                               : 16'($urandom_range(1, 40)));
         write_reg(REG_STACK_COUNT,
                   ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 2047))
                                               : 16'($urandom_range(1, 40)));
         slices_eff = (slice_reg > MAX_DIV) ? MAX_DIV : slice_reg;
         stacks_eff = (stack_reg > MAX_DIV) ? MAX_DIV : stack_reg;
         // First random phase: receiver holds off while requests pile up
         if (p == 0) begin
            hold_rsp  = 1'b1;
            burst_req = 1'b1;
         end
         for (int q = 0; q < QUADS_PER_PHASE; q++) begin
            if (q == 8) burst_req = 1'b0;
            if ($urandom_range(0, 6) == 0 || slices_eff == 0 || stacks_eff == 0) begin
               i = 10'($urandom);
               j = 10'($urandom);
            end else begin
               i = 10'($urandom_range(0, stacks_eff - 1));
               j = 10'($urandom_range(0, slices_eff - 1));
            end
            send_quad(i, j, 1'b0);
         end
      end

      req_valid <= 1'b0;
      wait (pending_vertices.size() == 0);
      repeat (500) @(posedge clock);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_div.sv
hw/rtl/uvs_sin.sv
hw/rtl/uvs_front.sv
hw/rtl/uvs_back.sv
hw/rtl/uv_sphere_vertex_generator.sv
sim/uv_sphere_vertex_generator_tb.sv
